// ----- sv/assert_macros.svh -----
// Assertion macros used by the deadlock safety check datapath.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define DSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the same cycle
`define DSC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Implication checked in the next cycle
`define DSC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- sv/dsc_pkg.sv -----
// Package for the deadlock safety check: sizes, action codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package dsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 16;
  localparam int AMOUNT_BITS   = 16;

  localparam int PROC_W  = $clog2(MAX_PROCESSES);
  localparam int RES_W   = $clog2(MAX_RESOURCES);
  localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int CFG_W   = 5;
  localparam int ADDR_W  = PROC_W + RES_W;
  localparam int DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
  // work entries hold available plus every allocation of a column
  localparam int WORK_W  = AMOUNT_BITS + $clog2(MAX_PROCESSES + 1);

  // configuration register indexes
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_CLAIM = 2'd1,
    ACT_AVAIL = 2'd2,
    ACT_CHECK = 2'd3
  } dsc_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_PROBE,
    ST_TEST_RD,
    ST_TEST_EV,
    ST_ADD_RD,
    ST_ADD_EV,
    ST_FINISH
  } dsc_state_t;

  typedef struct packed {
    logic write;        // store a load item
    logic start;        // begin a check: clear marks and tally
    logic copy_wr;      // work[k] <= available[k]
    logic k_clr;
    logic k_inc;
    logic p_clr;
    logic p_inc;
    logic mark;         // process p finished
    logic add;          // work[k] += alloc[p][k]
    logic result_load;  // fill the output register
  } dsc_cmd_t;

  typedef struct packed {
    logic copy_last;    // k is the last resource slot
    logic k_last;       // k is the last resource in use
    logic p_last;       // p is the last process in use
    logic p_done;       // process p already finished
    logic fits;         // claim <= alloc + work for resource k
    logic all_done;     // every process in use finished
    logic out_free;     // output register can take a result
  } dsc_stat_t;

endpackage

// ----- sv/deadlock_safety_check.sv -----
// Load item: stored on acceptance, no result. Check item: copy every available slot
// into work (read, write); probe each unfinished process by testing resources in use
// (read, evaluate) up to the first misfit, add its allocations on a finish, skip
// finished processes, then load the result once the output register is free.
// Synchronous reset clears the controller, counters, marks and output valid;
// stores are undefined until written and get no clearing pass.
module deadlock_safety_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [dsc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [3:0]                process_index,
  input  logic [3:0]                resource_index,
  input  logic [15:0]               amount,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      deadlock,
  output logic [4:0]                finished_count,
  output logic [15:0]               finished_map
);
  import dsc_pkg::*;

  dsc_cmd_t  cmd;
  dsc_stat_t stat;

  dsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .process_index  (process_index),
    .resource_index (resource_index),
    .amount         (amount),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .deadlock       (deadlock),
    .finished_count (finished_count),
    .finished_map   (finished_map)
  );

endmodule

// ----- sv/dsc_ctrl.sv -----
// Controller FSM for the deadlock safety check: sequences copy, probe,
// test and add phases. Depends on dsc_pkg.
module dsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          action,
  output logic                in_ready,
  input  dsc_pkg::dsc_stat_t  stat,
  output dsc_pkg::dsc_cmd_t   cmd
);
  import dsc_pkg::*;

  dsc_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (dsc_action_t'(action) == ACT_CHECK) begin
            cmd.start  = 1'b1;
            cmd.k_clr  = 1'b1;
            state_next = ST_COPY_RD;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_COPY_RD: begin
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (stat.copy_last) begin
          cmd.p_clr  = 1'b1;
          state_next = ST_PROBE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_COPY_RD;
        end
      end
      ST_PROBE: begin
        if (stat.all_done) begin
          state_next = ST_FINISH;
        end else if (stat.p_done) begin
          if (stat.p_last) begin
            state_next = ST_FINISH;
          end else begin
            cmd.p_inc = 1'b1;
          end
        end else begin
          cmd.k_clr  = 1'b1;
          state_next = ST_TEST_RD;
        end
      end
      ST_TEST_RD: begin
        state_next = ST_TEST_EV;
      end
      ST_TEST_EV: begin
        if (!stat.fits) begin
          if (stat.p_last) begin
            state_next = ST_FINISH;
          end else begin
            cmd.p_inc  = 1'b1;
            state_next = ST_PROBE;
          end
        end else if (stat.k_last) begin
          cmd.mark   = 1'b1;
          cmd.k_clr  = 1'b1;
          state_next = ST_ADD_RD;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_TEST_RD;
        end
      end
      ST_ADD_RD: begin
        state_next = ST_ADD_EV;
      end
      ST_ADD_EV: begin
        cmd.add = 1'b1;
        if (stat.k_last) begin
          // restart the scan from the first process
          cmd.p_clr  = 1'b1;
          state_next = ST_PROBE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_ADD_RD;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/dsc_datapath.sv -----
// Datapath for the deadlock safety check: matrix and available memories,
// work vector, finished marks, counters, config and output registers. Uses dsc_pkg.
`include "assert_macros.svh"

module dsc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [dsc_pkg::CFG_W-1:0]        cfg_data,
  input  logic [1:0]                       action,
  input  logic [3:0]                       process_index,
  input  logic [3:0]                       resource_index,
  input  logic [15:0]                      amount,
  input  dsc_pkg::dsc_cmd_t                cmd,
  output dsc_pkg::dsc_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             deadlock,
  output logic [4:0]                       finished_count,
  output logic [15:0]                      finished_map
);
  import dsc_pkg::*;

  logic [CFG_W-1:0]        process_count, resource_count;
  logic [CNT_W-1:0]        np, nr;
  logic [PROC_W-1:0]       p;
  logic [RES_W-1:0]        k;
  logic [CNT_W-1:0]        tally;
  logic [MAX_PROCESSES-1:0] done_marks;

  logic [AMOUNT_BITS-1:0]  alloc_mem [DEPTH];
  logic [AMOUNT_BITS-1:0]  claim_mem [DEPTH];
  logic [AMOUNT_BITS-1:0]  avail_mem [MAX_RESOURCES];
  logic [AMOUNT_BITS-1:0]  alloc_q, claim_q, avail_q;
  logic [WORK_W-1:0]       work_vector [MAX_RESOURCES];

  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [AMOUNT_BITS-1:0]  wr_data;
  logic [WORK_W-1:0]       alloc_ext, headroom;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= CFG_W'(MAX_PROCESSES);
      resource_count <= CFG_W'(MAX_RESOURCES);
    end else if (cfg_write) begin
      if (cfg_index == REG_PROCESS_COUNT) begin
        process_count <= cfg_data;
      end else begin
        resource_count <= cfg_data;
      end
    end
  end

  // clamp counts into 1..max
  always_comb begin
    if (process_count == '0) begin
      np = CNT_W'(1);
    end else if (process_count > CFG_W'(MAX_PROCESSES)) begin
      np = CNT_W'(MAX_PROCESSES);
    end else begin
      np = CNT_W'(process_count);
    end
    if (resource_count == '0) begin
      nr = CNT_W'(1);
    end else if (resource_count > CFG_W'(MAX_RESOURCES)) begin
      nr = CNT_W'(MAX_RESOURCES);
    end else begin
      nr = CNT_W'(resource_count);
    end
  end

  // memories: write on load transfer, registered read every cycle
  assign wr_addr = {process_index[PROC_W-1:0], resource_index[RES_W-1:0]};
  assign rd_addr = {p, k};
  assign wr_data = amount[AMOUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      case (dsc_action_t'(action))
        ACT_ALLOC: alloc_mem[wr_addr] <= wr_data;
        ACT_CLAIM: claim_mem[wr_addr] <= wr_data;
        ACT_AVAIL: avail_mem[resource_index[RES_W-1:0]] <= wr_data;
        default: ;
      endcase
    end
    alloc_q <= alloc_mem[rd_addr];
    claim_q <= claim_mem[rd_addr];
    avail_q <= avail_mem[k];
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
      k <= '0;
    end else begin
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + RES_W'(1);
      end
      if (cmd.p_clr) begin
        p <= '0;
      end else if (cmd.p_inc) begin
        p <= p + PROC_W'(1);
      end
    end
  end

  // work vector: copy from available, then accumulate allocations
  assign alloc_ext = WORK_W'(alloc_q);
  assign headroom  = alloc_ext + work_vector[k];

  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      work_vector[k] <= WORK_W'(avail_q);
    end else if (cmd.add) begin
      work_vector[k] <= headroom;
    end
  end

  // finished marks and tally
  always_ff @(posedge clk) begin
    if (rst) begin
      done_marks <= '0;
      tally      <= '0;
    end else if (cmd.start) begin
      done_marks <= '0;
      tally      <= '0;
    end else if (cmd.mark) begin
      done_marks[p] <= 1'b1;
      tally         <= tally + CNT_W'(1);
    end
  end

  // status to the controller
  always_comb begin
    stat.copy_last = (k == RES_W'(MAX_RESOURCES - 1));
    stat.k_last    = (CNT_W'(k) == nr - CNT_W'(1));
    stat.p_last    = (CNT_W'(p) == np - CNT_W'(1));
    stat.p_done    = done_marks[p];
    stat.fits      = (WORK_W'(claim_q) <= headroom);
    stat.all_done  = (tally == np);
    stat.out_free  = !out_valid || out_ready;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      deadlock       <= (tally < np);
      finished_count <= 5'(tally);
      finished_map   <= 16'(done_marks);
    end
  end

  `DSC_ASSERT(a_tally_matches_marks, $countones(done_marks) == 32'(tally), "tally out of step with marks")
  `DSC_ASSERT_IMP(a_mark_fresh, cmd.mark, !done_marks[p], "process marked finished twice")
  `DSC_ASSERT_IMP(a_load_slot_free, cmd.result_load, !out_valid || out_ready, "result overwrote a pending result")

endmodule

// ----- tb/tb_deadlock_safety_check.sv -----
// Testbench for deadlock_safety_check: loads the allocation, claim and available stores,
// runs safety checks under several size settings and compares each verdict with a local scan.
// Depends on dsc_pkg and the deadlock_safety_check RTL.
module tb_deadlock_safety_check;
  import dsc_pkg::*;

  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 110;
  localparam int PRESSURE_PHASE = 2;
  localparam int BURST_ITEMS    = 40;
  localparam int HOLD_CYCLES    = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct {
    bit              deadlock;
    logic [4:0]      count;
    logic [15:0]     map;
  } verdict_t;

  // Scoreboard: mirrors the stores and the size registers, predicts each check
  class safety_ledger;
    logic [AMOUNT_BITS-1:0] alloc_units [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] claim_units [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] avail_units [MAX_RESOURCES];
    logic [CFG_W-1:0]       process_reg;
    logic [CFG_W-1:0]       resource_reg;
    verdict_t               pending_verdicts [$];
    int                     errors;
    int                     verdicts_checked;
    int                     deadlocks_predicted;

    function new();
      process_reg         = 5'd16;
      resource_reg        = 5'd16;
      errors              = 0;
      verdicts_checked    = 0;
      deadlocks_predicted = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_PROCESS_COUNT)
        process_reg = value;
      else
        resource_reg = value;
    endfunction

    // out-of-range sizes are clamped into 1..16 by the block
    function int clamp_size(logic [CFG_W-1:0] v);
      if (v == 0)
        return 1;
      if (v > 16)
        return 16;
      return v;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Safety scan: lowest-index process that fits finishes and releases its allocation
    function verdict_t scan_safe_order();
      verdict_t      v;
      logic [WORK_W:0] work [MAX_RESOURCES];
      bit            done [MAX_PROCESSES];
      int            np, nr, tally, p, k;
      bit            progress, fits;
      np = clamp_size(process_reg);
      nr = clamp_size(resource_reg);
      for (k = 0; k < MAX_RESOURCES; k++)
        work[k] = avail_units[k];
      for (p = 0; p < MAX_PROCESSES; p++)
        done[p] = 1'b0;
      tally    = 0;
      progress = 1'b1;
      while (tally < np && progress) begin
        progress = 1'b0;
        for (p = 0; p < np && !progress; p++) begin
          if (!done[p]) begin
            fits = 1'b1;
            // claim below allocation never blocks: the sum stays unsigned
            for (k = 0; k < nr; k++)
              if (claim_units[p][k] > alloc_units[p][k] + work[k])
                fits = 1'b0;
            if (fits) begin
              done[p] = 1'b1;
              tally++;
              for (k = 0; k < nr; k++)
                work[k] += alloc_units[p][k];
              progress = 1'b1;
            end
          end
        end
      end
      v.map = '0;
      for (p = 0; p < np; p++)
        if (done[p])
          v.map[p] = 1'b1;
      v.deadlock = (tally < np);
      v.count    = 5'(tally);
      return v;
    endfunction

    // Accepted input transfer: update a store or queue the expected verdict
    function void note_item(dsc_action_t act, logic [3:0] pi, logic [3:0] ri,
                            logic [15:0] amt);
      verdict_t v;
      case (act)
        ACT_ALLOC: alloc_units[pi][ri] = amt;
        ACT_CLAIM: claim_units[pi][ri] = amt;
        ACT_AVAIL: avail_units[ri]     = amt;
        ACT_CHECK: begin
          v = scan_safe_order();
          if (v.deadlock)
            deadlocks_predicted++;
          pending_verdicts.push_back(v);
        end
      endcase
    endfunction

    // Accepted output transfer: compare with the oldest expectation
    function void check_verdict(logic dl, logic [4:0] cnt, logic [15:0] map);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: deadlock=%0b finished_count=%0d finished_map=%h",
               dl, cnt, map);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      verdicts_checked++;
      if (dl !== v.deadlock) begin
        $error("deadlock: expected %0b, got %0b", v.deadlock, dl);
        errors++;
      end
      if (cnt !== v.count) begin
        $error("finished_count: expected %0d, got %0d", v.count, cnt);
        errors++;
      end
      if (map !== v.map) begin
        $error("finished_map: expected %h, got %h", v.map, map);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst            = 1'b1;
  logic              cfg_write      = 1'b0;
  logic              cfg_index      = REG_PROCESS_COUNT;
  logic [CFG_W-1:0]  cfg_data       = '0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  dsc_action_t       action         = ACT_ALLOC;
  logic [3:0]        process_index  = '0;
  logic [3:0]        resource_index = '0;
  logic [15:0]       amount         = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              deadlock;
  logic [4:0]        finished_count;
  logic [15:0]       finished_map;

  safety_ledger ledger;
  bit           send_idle_en  = 1'b1;
  bit           recv_idle_en  = 1'b1;
  bit           stall_request = 1'b0;
  int           items_in      = 0;

  int phase_np [NUM_PHASES] = '{16, 1, 2, 3, 4, 8, 2, 0, 31, 6, 16, 5};
  int phase_nr [NUM_PHASES] = '{16, 1, 2, 5, 3, 2, 8, 31, 0, 4, 3, 16};

  deadlock_safety_check DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .action, .process_index, .resource_index, .amount,
    .out_valid, .out_ready, .deadlock, .finished_count, .finished_map
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One input transfer after a random gap
  task automatic offer_item(dsc_action_t act, logic [3:0] pi, logic [3:0] ri,
                            logic [15:0] amt);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    process_index  <= pi;
    resource_index <= ri;
    amount         <= amt;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(act, pi, ri, amt);
    items_in++;
  endtask

  // Wait for every verdict, then give trailing load items time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(int np, int nr);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_PROCESS_COUNT;
    cfg_data  <= CFG_W'(np);
    @(posedge clk);
    ledger.write_reg(REG_PROCESS_COUNT, CFG_W'(np));
    cfg_index <= REG_RESOURCE_COUNT;
    cfg_data  <= CFG_W'(nr);
    @(posedge clk);
    ledger.write_reg(REG_RESOURCE_COUNT, CFG_W'(nr));
    cfg_write <= 1'b0;
  endtask

  // Mostly small amounts so checks split between safe and deadlocked states;
  // claims usually sit just above the current allocation
  function automatic logic [15:0] pick_amount(dsc_action_t act, logic [3:0] pi,
                                              logic [3:0] ri);
    int sel;
    int base;
    sel = $urandom_range(0, 19);
    if (sel >= 15) begin
      case ($urandom_range(0, 2))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        default: return 16'($urandom_range(0, 65535));
      endcase
    end
    case (act)
      ACT_CLAIM: begin
        base = ledger.alloc_units[pi][ri];
        if (sel < 12) begin
          base = base + $urandom_range(0, 4);
          return 16'((base > 65535) ? 65535 : base);
        end
        return 16'($urandom_range(0, base));
      end
      ACT_AVAIL: return 16'($urandom_range(0, 6));
      default:   return 16'($urandom_range(0, 5));
    endcase
  endfunction

  task automatic random_item(int np, int nr);
    int          check_pct;
    dsc_action_t act;
    logic [3:0]  pi, ri;
    check_pct = (np * nr > 40) ? 4 : 15;
    // rows and columns mostly inside the active sizes
    pi = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, np - 1));
    ri = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, nr - 1));
    if ($urandom_range(0, 99) < check_pct)
      offer_item(ACT_CHECK, pi, ri, 16'($urandom_range(0, 65535)));
    else begin
      act = dsc_action_t'($urandom_range(0, 2));
      offer_item(act, pi, ri, pick_amount(act, pi, ri));
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_idle_en ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      ledger.check_verdict(deadlock, finished_count, finished_map);
    end
  end

  // Watchdog: cycles with no transfer on any port
  initial begin
    int quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int ph, p, r, np_eff, nr_eff;
    ledger = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every store entry so no check reads an unwritten one
    for (r = 0; r < MAX_RESOURCES; r++)
      offer_item(ACT_AVAIL, 4'($urandom_range(0, 15)), 4'(r),
                 pick_amount(ACT_AVAIL, 4'd0, 4'(r)));
    for (p = 0; p < MAX_PROCESSES; p++)
      for (r = 0; r < MAX_RESOURCES; r++)
        offer_item(ACT_ALLOC, 4'(p), 4'(r), pick_amount(ACT_ALLOC, 4'(p), 4'(r)));
    for (p = 0; p < MAX_PROCESSES; p++)
      for (r = 0; r < MAX_RESOURCES; r++)
        offer_item(ACT_CLAIM, 4'(p), 4'(r), pick_amount(ACT_CLAIM, 4'(p), 4'(r)));

    // directed: full sizes after reset, field extremes
    offer_item(ACT_CHECK, 4'd0, 4'd0, 16'h0000);
    offer_item(ACT_AVAIL, 4'd15, 4'd0, 16'h0000);
    offer_item(ACT_AVAIL, 4'd0, 4'd15, 16'hFFFF);
    offer_item(ACT_ALLOC, 4'd15, 4'd15, 16'hFFFF);
    offer_item(ACT_CLAIM, 4'd15, 4'd15, 16'hFFFF);
    // claim below allocation on process 0
    offer_item(ACT_ALLOC, 4'd0, 4'd0, 16'd9);
    offer_item(ACT_CLAIM, 4'd0, 4'd0, 16'd2);
    offer_item(ACT_CHECK, 4'd15, 4'd15, 16'hFFFF);
    // huge claim that only a large work vector could cover
    offer_item(ACT_CLAIM, 4'd3, 4'd7, 16'hFFFF);
    offer_item(ACT_CHECK, 4'd3, 4'd7, 16'h5A5A);
    offer_item(ACT_CLAIM, 4'd3, 4'd7, 16'd0);
    offer_item(ACT_CHECK, 4'd0, 4'd0, 16'h0000);
    // size registers at and beyond their limits
    settle();
    set_sizes(0, 31);
    offer_item(ACT_CHECK, 4'd0, 4'd0, 16'h0000);
    settle();
    set_sizes(31, 0);
    offer_item(ACT_CHECK, 4'd0, 4'd0, 16'h0000);
    settle();
    set_sizes(1, 1);
    offer_item(ACT_CHECK, 4'd0, 4'd0, 16'h0000);

    // random phases, one size setting each
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      set_sizes(phase_np[ph], phase_nr[ph]);
      send_idle_en = (ph % 4 != 1);
      recv_idle_en = (ph % 4 != 1);
      np_eff = ledger.clamp_size(CFG_W'(phase_np[ph]));
      nr_eff = ledger.clamp_size(CFG_W'(phase_nr[ph]));
      if (ph == PRESSURE_PHASE) begin
        // back-to-back checks while the result side holds off
        stall_request = 1'b1;
        send_idle_en  = 1'b0;
        repeat (BURST_ITEMS)
          offer_item(ACT_CHECK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     16'($urandom_range(0, 65535)));
        send_idle_en = 1'b1;
      end
      repeat (PHASE_ITEMS) random_item(np_eff, nr_eff);
    end

    // drain and let trailing writes complete
    in_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transfers and %0d verdicts over %0d size settings",
             items_in, ledger.verdicts_checked, NUM_PHASES + 4);
    $display("%0d verdicts reported deadlock; one %0d-cycle output hold-off backed up the input",
             ledger.deadlocks_predicted, HOLD_CYCLES);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- deadlock_safety_check.f -----
+incdir+sv
sv/dsc_pkg.sv
sv/dsc_ctrl.sv
sv/dsc_datapath.sv
sv/deadlock_safety_check.sv
tb/tb_deadlock_safety_check.sv
